### rtl/phe_pkg.sv
`default_nettype none

package phe_pkg;

  // Number format and polynomial size.
  localparam int WORD_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_DEGREE = 6;
  localparam int NUM_COEF   = MAX_DEGREE + 1;
  localparam int NUM_STEPS  = NUM_COEF;
  localparam int PROD_W     = 2 * WORD_W;

  // Register file layout.
  localparam int DEG_W      = 3;
  localparam int NUM_REGS   = NUM_COEF + 1;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS);
  localparam int COEF_IDX_W = (NUM_COEF > 1) ? $clog2(NUM_COEF) : 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST = CFG_IDX_W'(NUM_COEF);

  // Half an LSB of the result, added before the product is floored.
  localparam logic signed [PROD_W-1:0] ROUND_HALF =
    (PROD_W'(1) << FRAC_BITS) >> 1;

  localparam logic signed [PROD_W-1:0] WIDE_MAX = (PROD_W'(1) << (WORD_W - 1)) - 1;
  localparam logic signed [PROD_W-1:0] WIDE_MIN = -(PROD_W'(1) << (WORD_W - 1));

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic  ovf;
    word_t value;
  } sat_t;

  // Clamps a wide signed value into one word and reports whether it clipped.
  function automatic sat_t sat_word(input prod_t v);
    sat_t r;
    if (v > WIDE_MAX) begin
      r.ovf   = 1'b1;
      r.value = WIDE_MAX[WORD_W-1:0];
    end else if (v < WIDE_MIN) begin
      r.ovf   = 1'b1;
      r.value = WIDE_MIN[WORD_W-1:0];
    end else begin
      r.ovf   = 1'b0;
      r.value = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/polynomial_horner_evaluator.sv
`default_nettype none

// Polynomial evaluator by Horner's rule in signed Q15.16 fixed point.
// Set the degree (register 0) and coefficients coef_0..coef_6 (registers
// 1..7) through cfg_write/cfg_index/cfg_data while no word is in flight.
// A degree above six acts as six; coefficients above the degree are ignored.
// Each x_value word accepted on the input channel (in_valid and in_ready
// both high) yields exactly one output word carrying poly_value and the
// overflowed flag, which is set when any rounding multiply or coefficient
// add had to saturate.
// Every Horner step is two register stages: a 32 by 32 multiply, then
// rounding, saturation, the coefficient add and a second saturation. With
// seven steps there are 14 register stages, the multiply and add stages of
// each step in turn, and out_valid is the valid bit of the last add stage.
// While out_ready stays high no stage ever holds a word back, so the
// pipeline takes one word per cycle.
// Reset clears the valid bits, the degree and all coefficients to zero.
// Each stage has its own ready, so when the receiver holds out_ready low the
// last word waits on the outputs while bubbles further up are squeezed out
// and new words keep entering until the pipeline is full.

module polynomial_horner_evaluator (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_write,
  input  wire  [phe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [phe_pkg::WORD_W-1:0]           cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  signed [phe_pkg::WORD_W-1:0]    x_value,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [phe_pkg::WORD_W-1:0]    poly_value,
  output logic                                 overflowed
);

  localparam int STEPS = phe_pkg::NUM_STEPS;

  // Configuration registers.
  logic [phe_pkg::DEG_W-1:0]      degree;
  phe_pkg::word_t                 coef [phe_pkg::NUM_COEF];
  logic [phe_pkg::DEG_W-1:0]      deg_eff;
  logic [phe_pkg::CFG_IDX_W-1:0]  coef_off;
  logic [phe_pkg::COEF_IDX_W-1:0] coef_sel;

  assign coef_off = cfg_index - phe_pkg::CFG_COEF_BASE;
  assign coef_sel = coef_off[phe_pkg::COEF_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= '0;
      for (int i = 0; i < phe_pkg::NUM_COEF; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        phe_pkg::CFG_DEGREE: begin
          degree <= cfg_data[phe_pkg::DEG_W-1:0];
        end
        default: begin
          if (cfg_index <= phe_pkg::CFG_COEF_LAST) begin
            coef[coef_sel] <= cfg_data;
          end
        end
      endcase
    end
  end

  // A degree beyond the largest supported one is treated as the largest.
  assign deg_eff = (degree > phe_pkg::DEG_W'(phe_pkg::MAX_DEGREE)) ?
                   phe_pkg::DEG_W'(phe_pkg::MAX_DEGREE) : degree;

  // Multiply stage registers of each step.
  logic           vm     [STEPS];
  logic           rdy_m  [STEPS];
  phe_pkg::prod_t prod   [STEPS];
  logic           ovf_m  [STEPS];
  phe_pkg::word_t x_m    [STEPS];

  // Add stage registers of each step.
  logic           va     [STEPS];
  logic           rdy_a  [STEPS];
  phe_pkg::word_t acc    [STEPS];
  logic           ovf_a  [STEPS];
  phe_pkg::word_t x_a    [STEPS];

  wire [2*STEPS-1:0] valid_bus;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    // Step k folds in the coefficient of x to the power MAX_DEGREE - k.
    localparam int CIDX = phe_pkg::MAX_DEGREE - k;

    logic           v_in;
    logic           ovf_in;
    phe_pkg::word_t acc_in;
    phe_pkg::word_t x_in;
    phe_pkg::word_t coef_use;
    phe_pkg::prod_t rnd;
    phe_pkg::sat_t  mul_sat;
    phe_pkg::sat_t  add_sat;
    logic signed [phe_pkg::WORD_W:0] sum;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign acc_in = '0;
      assign ovf_in = 1'b0;
      assign x_in   = x_value;
    end else begin : g_next
      assign v_in   = va[k-1];
      assign acc_in = acc[k-1];
      assign ovf_in = ovf_a[k-1];
      assign x_in   = x_a[k-1];
    end

    if (k == STEPS - 1) begin : g_last
      assign rdy_a[k] = !va[k] || out_ready;
    end else begin : g_mid
      assign rdy_a[k] = !va[k] || rdy_m[k+1];
    end
    assign rdy_m[k] = !vm[k] || rdy_a[k];

    // Coefficients above the degree read as zero; the accumulator is still
    // zero there, so those steps leave it untouched.
    assign coef_use = (phe_pkg::DEG_W'(CIDX) <= deg_eff) ? coef[CIDX] : '0;

    always_ff @(posedge clk) begin
      if (rst) begin
        vm[k] <= 1'b0;
      end else if (rdy_m[k]) begin
        vm[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy_m[k] && v_in) begin
        prod[k]  <= phe_pkg::PROD_W'(acc_in) * phe_pkg::PROD_W'(x_in);
        ovf_m[k] <= ovf_in;
        x_m[k]   <= x_in;
      end
    end

    // Round half up, then floor back to the fraction width.
    assign rnd     = (prod[k] + phe_pkg::ROUND_HALF) >>> phe_pkg::FRAC_BITS;
    assign mul_sat = phe_pkg::sat_word(rnd);
    assign sum     = (phe_pkg::WORD_W+1)'(mul_sat.value) +
                     (phe_pkg::WORD_W+1)'(coef_use);
    assign add_sat = phe_pkg::sat_word(phe_pkg::PROD_W'(sum));

    always_ff @(posedge clk) begin
      if (rst) begin
        va[k] <= 1'b0;
      end else if (rdy_a[k]) begin
        va[k] <= vm[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy_a[k] && vm[k]) begin
        acc[k]   <= add_sat.value;
        ovf_a[k] <= ovf_m[k] | mul_sat.ovf | add_sat.ovf;
        x_a[k]   <= x_m[k];
      end
    end

    assign valid_bus[2*k]   = vm[k];
    assign valid_bus[2*k+1] = va[k];
  end

  assign in_ready   = rdy_m[0];
  assign out_valid  = va[STEPS-1];
  assign poly_value = acc[STEPS-1];
  assign overflowed = ovf_a[STEPS-1];

  // Words are neither lost nor duplicated inside the pipeline.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |->
      $countones(valid_bus) == $past($countones(valid_bus))
        + $past(in_valid && in_ready) - $past(out_valid && out_ready))
    else $error("pipeline occupancy does not match accepted and delivered words");

  // The input is refused only when every stage is full and the output stalls.
  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&valid_bus) && !out_ready)
    else $error("input refused while the pipeline has room");

  // The first step always starts from a zero accumulator.
  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    vm[0] |-> prod[0] == '0)
    else $error("first Horner step saw a nonzero accumulator");

endmodule

`default_nettype wire

### test/polynomial_horner_evaluator_tb.sv
`timescale 1ns / 1ps

// Testbench for the Horner polynomial evaluator.
// A driver and a monitor run as clocked processes around the block. The driver
// takes x words from a backlog that the stimulus process fills, and the monitor
// takes poly_value/overflowed words and compares them against the predictions
// made when each x word was accepted.
module polynomial_horner_evaluator_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  localparam logic signed [63:0] WORD_HI = 64'sh000000007FFFFFFF;
  localparam logic signed [63:0] WORD_LO = -64'sh0000000080000000;

  typedef struct {
    logic [phe_pkg::WORD_W-1:0] value;
    logic                       ovf;
  } poly_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [phe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [phe_pkg::WORD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [phe_pkg::WORD_W-1:0] x_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [phe_pkg::WORD_W-1:0] poly_value;
  logic overflowed;

  // Shadow copy of the register file, used by the predictor.
  logic [phe_pkg::DEG_W-1:0] deg_shadow = '0;
  logic signed [phe_pkg::WORD_W-1:0] coef_shadow [0:phe_pkg::NUM_COEF-1];

  logic [phe_pkg::WORD_W-1:0] x_backlog [$];
  poly_word_t expected_poly [$];

  int errors = 0;
  int cycle_count = 0;
  int results_seen = 0;

  // Idle bookkeeping for both sides.
  int gap_left = 0;
  int drv_calm = 0;
  int stall_left = 0;
  int mon_calm = 0;
  int hold_left = 0;
  int holds_done = 0;

  poly_word_t want;

  polynomial_horner_evaluator uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .x_value    (x_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .poly_value (poly_value),
    .overflowed (overflowed)
  );

  always #5 clk = ~clk;

  // Clamps a wide value to one word; the top bit of the result tells whether it clipped.
  function automatic logic [phe_pkg::WORD_W:0] clip_word(input logic signed [63:0] v);
    if (v > WORD_HI) return {1'b1, 32'h7FFFFFFF};
    if (v < WORD_LO) return {1'b1, 32'h80000000};
    return {1'b0, v[phe_pkg::WORD_W-1:0]};
  endfunction

  // Horner's rule over the shadow registers. Each product is rounded half up
  // (add half an LSB, then an arithmetic shift, which floors) and clamped, and
  // each coefficient sum is clamped again. A degree of seven acts as six.
  function automatic poly_word_t horner_predict(input logic signed [phe_pkg::WORD_W-1:0] x);
    poly_word_t r;
    logic signed [63:0] acc;
    logic signed [63:0] x_wide;
    logic signed [63:0] prod;
    logic [phe_pkg::WORD_W:0] c;
    logic ovf;
    int top;
    x_wide = x;
    acc = 0;
    ovf = 1'b0;
    top = (deg_shadow > phe_pkg::MAX_DEGREE) ? phe_pkg::MAX_DEGREE : deg_shadow;
    for (int i = top; i >= 0; i--) begin
      prod = acc * x_wide;
      if (phe_pkg::FRAC_BITS > 0) begin
        prod = (prod + (64'sd1 <<< (phe_pkg::FRAC_BITS - 1))) >>> phe_pkg::FRAC_BITS;
      end
      c = clip_word(prod);
      ovf = ovf | c[phe_pkg::WORD_W];
      acc = $signed(c[phe_pkg::WORD_W-1:0]);
      c = clip_word(acc + coef_shadow[i]);
      ovf = ovf | c[phe_pkg::WORD_W];
      acc = $signed(c[phe_pkg::WORD_W-1:0]);
    end
    r.value = acc[phe_pkg::WORD_W-1:0];
    r.ovf = ovf;
    return r;
  endfunction

  // Random word: mostly values of modest size so the arithmetic stays in range,
  // with full-width noise and the corners of the format mixed in.
  function automatic logic [phe_pkg::WORD_W-1:0] rand_word(input int scale);
    int span;
    span = 1 << scale;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFFFFFF;
          1: return 32'h80000000;
          2: return 32'h00010000;
          3: return 32'hFFFF0000;
          default: return 32'h00000000;
        endcase
      end
      default: return $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  // Draws the idle count for the next word. Now and then a side enters a calm
  // stretch in which it does not idle at all.
  task automatic draw_idle(inout int calm, output int gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(0, 31) == 0) begin
      calm = $urandom_range(20, 60);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 18);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  // Appends one x word to the end of the backlog.
  task automatic add_backlog(input logic [phe_pkg::WORD_W-1:0] v);
    x_backlog.insert(x_backlog.size(), v);
  endtask

  // Writes one register at the next edge and mirrors it in the shadow copy.
  task automatic write_reg(input logic [phe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [phe_pkg::WORD_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == phe_pkg::CFG_DEGREE) begin
      deg_shadow = data[phe_pkg::DEG_W-1:0];
    end else begin
      coef_shadow[idx - phe_pkg::CFG_COEF_BASE] = data;
    end
  endtask

  task automatic write_coef(input int k, input logic [phe_pkg::WORD_W-1:0] data);
    write_reg(phe_pkg::CFG_IDX_W'(phe_pkg::CFG_COEF_BASE + k), data);
  endtask

  task automatic finish_writes;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until no word is pending, offered or in flight. Sampled on the
  // falling edge so the queues are settled.
  task automatic wait_idle;
    @(negedge clk);
    while (x_backlog.size() != 0 || in_valid || expected_poly.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Driver: offers the next x word once the previous one is taken and its
  // idle count has run out. A word that is offered stays put until accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      x_value <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_poly.insert(expected_poly.size(), horner_predict(x_value));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (x_backlog.size() > 0) begin
          in_valid <= 1'b1;
          x_value <= x_backlog.pop_front();
          draw_idle(drv_calm, gap_left);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver holds: twice during the run, once enough words are waiting
  // in the backlog, out_ready is held low for a countdown from HOLD_CYCLES so the
  // pipeline fills up and pushes back on the driver.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (holds_done < 2 && x_backlog.size() >= 30 &&
                 results_seen >= ((holds_done == 0) ? 150 : 700)) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
  end

  // Monitor: checks each accepted result word against the oldest prediction,
  // and keeps out_ready low while a long hold runs.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_poly.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", poly_value));
        end else begin
          want = expected_poly.pop_front();
          if (poly_value !== want.value) begin
            report_mismatch($sformatf("poly_value %h, expected %h", poly_value, want.value));
          end
          if (overflowed !== want.ovf) begin
            report_mismatch($sformatf("overflowed %b, expected %b", overflowed, want.ovf));
          end
        end
        results_seen++;
        draw_idle(mon_calm, stall_left);
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    for (int k = 0; k < phe_pkg::NUM_COEF; k++) begin
      coef_shadow[k] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Registers straight out of reset: every x must give zero.
    @(negedge clk);
    add_backlog(32'h00000000);
    add_backlog(32'h7FFFFFFF);
    add_backlog(32'h80000000);

    // Rounding of the product, half up: with p(x) = LSB * x, an x of one half
    // rounds up to one LSB and minus one half rounds up to zero. The upper
    // coefficients carry junk that the degree must mask out.
    wait_idle();
    write_reg(phe_pkg::CFG_DEGREE, 1);
    write_coef(0, 32'h00000000);
    write_coef(1, 32'h00000001);
    write_coef(2, 32'h12345678);
    write_coef(3, 32'hDEADBEEF);
    write_coef(4, 32'h7FFFFFFF);
    write_coef(5, 32'h80000000);
    write_coef(6, 32'h55AA55AA);
    finish_writes();
    add_backlog(32'h00008000);
    add_backlog(32'hFFFF8000);
    add_backlog(32'h00007FFF);
    add_backlog(32'h00018000);

    // Saturation on the coefficient add, in both directions.
    wait_idle();
    write_coef(1, 32'h7FFFFFFF);
    write_coef(0, 32'h7FFFFFFF);
    finish_writes();
    add_backlog(32'h00010000);
    add_backlog(32'hFFFF0000);
    wait_idle();
    write_coef(0, 32'h80000000);
    finish_writes();
    add_backlog(32'hFFFF0000);

    // A degree of seven is treated as six.
    wait_idle();
    write_reg(phe_pkg::CFG_DEGREE, 7);
    write_coef(0, 32'h00010000);
    write_coef(1, 32'hFFFF0000);
    write_coef(2, 32'h00008000);
    write_coef(3, 32'h00000100);
    write_coef(4, 32'hFFFFFF00);
    write_coef(5, 32'h00000010);
    write_coef(6, 32'h00000001);
    finish_writes();
    add_backlog(32'h00010000);
    add_backlog(32'h00020000);
    add_backlog(32'h7FFFFFFF);
    add_backlog(32'h80000000);

    // Full degree with every coefficient at the top, then at the bottom of the range.
    wait_idle();
    write_reg(phe_pkg::CFG_DEGREE, 6);
    for (int k = 0; k < phe_pkg::NUM_COEF; k++) begin
      write_coef(k, 32'h7FFFFFFF);
    end
    finish_writes();
    add_backlog(32'h7FFFFFFF);
    add_backlog(32'h80000000);
    add_backlog(32'h00000000);
    wait_idle();
    for (int k = 0; k < phe_pkg::NUM_COEF; k++) begin
      write_coef(k, 32'h80000000);
    end
    finish_writes();
    add_backlog(32'h7FFFFFFF);
    add_backlog(32'h00010000);

    // Random phases. Each one rewrites most of the registers and then sends a
    // batch of x words, mostly small enough to keep the sums in range.
    for (int p = 0; p < 20; p++) begin
      wait_idle();
      if (p == 0 || $urandom_range(0, 3) != 0) begin
        write_reg(phe_pkg::CFG_DEGREE, $urandom_range(0, 7));
      end
      for (int k = 0; k < phe_pkg::NUM_COEF; k++) begin
        if (p == 0 || $urandom_range(0, 3) != 0) begin
          write_coef(k, rand_word(20));
        end
      end
      finish_writes();
      n = $urandom_range(35, 65);
      repeat (n) add_backlog(rand_word(17));
    end

    // Drain, then give the pipeline time to show any stray word.
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### polynomial_horner_evaluator.f
rtl/phe_pkg.sv
rtl/polynomial_horner_evaluator.sv
test/polynomial_horner_evaluator_tb.sv
